// ----- rtl/hsv_pkg.sv -----
// Shared types and constants for the HSV to RGB converter.
// No dependencies; the interfaces and the top level import this package.
package hsv_pkg;

   // Field widths.
   localparam int unsigned HUE_W  = 9;
   localparam int unsigned CHAN_W = 8;
   localparam int unsigned REM_W  = 6;
   localparam int unsigned FINE_W = 14;

   // Hue range and sextant size, in degrees.
   localparam logic [HUE_W-1:0] HUE_LIMIT = 9'd360;
   localparam logic [REM_W-1:0] SEXT_DEG  = 6'd60;

   // Full channel level and the fine scale 255 * 60.
   localparam logic [CHAN_W-1:0] FULL_LEVEL = 8'd255;
   localparam logic [FINE_W-1:0] FINE_SCALE = 14'd15300;

   // Division by 15300 is done as a shift by two and a division by 3825.
   // The reciprocal is ceil(2^32 / 3825); it is exact for all 20-bit dividends here.
   localparam int unsigned       RECIP_W     = 21;
   localparam logic [RECIP_W-1:0] RECIP_3825 = 21'd1122868;
   localparam int unsigned       RECIP_SHIFT = 32;

   // Hue sextants, named by the colors at their edges.
   typedef enum logic [2:0] {
      SEXT_RED_YELLOW,
      SEXT_YELLOW_GREEN,
      SEXT_GREEN_CYAN,
      SEXT_CYAN_BLUE,
      SEXT_BLUE_MAGENTA,
      SEXT_MAGENTA_RED
   } sextant_type;

endpackage

// ----- rtl/hsv_if.sv -----
// Request and response channel interfaces of the HSV to RGB converter.
// Depends on hsv_pkg for the field widths.
interface hsv_req_if
   import hsv_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue_deg;
   logic [CHAN_W-1:0] saturation;
   logic [CHAN_W-1:0] brightness;

   modport source (output valid, output hue_deg, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue_deg, input saturation, input brightness,
                   output ready);
endinterface

interface hsv_rsp_if
   import hsv_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic              hue_error;

   modport source (output valid, output red, output green, output blue, output hue_error,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input hue_error,
                   output ready);
endinterface

// ----- rtl/hsv_to_rgb_converter.sv -----
// HSV to RGB converter with 8-bit channels. It takes one request per clock unless the
// response register is full and not taken. Each request passes through a five-stage
// pipeline (sextant split, saturation products, brightness products, constant division,
// channel routing) that stalls as a whole only while the response register is full and
// not taken. A hue above 359 returns black with hue_error set; a saturation of zero
// returns gray.
// Depends on hsv_pkg and on the hsv_req_if / hsv_rsp_if interfaces.
module hsv_to_rgb_converter
   import hsv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hsv_req_if.sink   req_bus,
   hsv_rsp_if.source rsp_bus
);

   // Pipeline advance: the whole pipe moves when the response register is free or taken.
   logic advance;
   logic out_valid_ff;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // ---------------- Stage 1: split the hue into sextant and remainder ----------------
   sextant_type       sext_in;
   logic [HUE_W-1:0]  base_in;
   logic [REM_W-1:0]  rem_in;
   logic              err_in;

   logic              s1_valid_ff;
   sextant_type       s1_sext_ff;
   logic [REM_W-1:0]  s1_rem_ff;
   logic [CHAN_W-1:0] s1_sat_ff;
   logic [CHAN_W-1:0] s1_val_ff;
   logic              s1_err_ff;

   // Compare the hue against the sextant edges; out-of-range hues fall in the last.
   always_comb begin
      priority if (req_bus.hue_deg < 9'd60) begin
         sext_in = SEXT_RED_YELLOW;
         base_in = 9'd0;
      end else if (req_bus.hue_deg < 9'd120) begin
         sext_in = SEXT_YELLOW_GREEN;
         base_in = 9'd60;
      end else if (req_bus.hue_deg < 9'd180) begin
         sext_in = SEXT_GREEN_CYAN;
         base_in = 9'd120;
      end else if (req_bus.hue_deg < 9'd240) begin
         sext_in = SEXT_CYAN_BLUE;
         base_in = 9'd180;
      end else if (req_bus.hue_deg < 9'd300) begin
         sext_in = SEXT_BLUE_MAGENTA;
         base_in = 9'd240;
      end else begin
         sext_in = SEXT_MAGENTA_RED;
         base_in = 9'd300;
      end
      rem_in = REM_W'(req_bus.hue_deg - base_in);
      err_in = (req_bus.hue_deg >= HUE_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sext_ff <= sext_in;
         s1_rem_ff  <= rem_in;
         s1_sat_ff  <= req_bus.saturation;
         s1_val_ff  <= req_bus.brightness;
         s1_err_ff  <= err_in;
      end
   end

   // ---------------- Stage 2: saturation terms ----------------
   logic [CHAN_W-1:0] t1_in;
   logic [FINE_W-1:0] t2_in;
   logic [FINE_W-1:0] t3_in;

   logic              s2_valid_ff;
   sextant_type       s2_sext_ff;
   logic [CHAN_W-1:0] s2_val_ff;
   logic              s2_err_ff;
   logic [CHAN_W-1:0] s2_t1_ff;
   logic [FINE_W-1:0] s2_t2_ff;
   logic [FINE_W-1:0] s2_t3_ff;

   // The products never exceed the fine scale, so the differences stay non-negative.
   always_comb begin
      t1_in = FULL_LEVEL - s1_sat_ff;
      t2_in = FINE_SCALE - FINE_W'(s1_sat_ff) * FINE_W'(s1_rem_ff);
      t3_in = FINE_SCALE - FINE_W'(s1_sat_ff) * FINE_W'(REM_W'(SEXT_DEG - s1_rem_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sext_ff <= s1_sext_ff;
         s2_val_ff  <= s1_val_ff;
         s2_err_ff  <= s1_err_ff;
         s2_t1_ff   <= t1_in;
         s2_t2_ff   <= t2_in;
         s2_t3_ff   <= t3_in;
      end
   end

   // ---------------- Stage 3: scale by brightness ----------------
   localparam int unsigned P1_W = 2 * CHAN_W;
   localparam int unsigned P2_W = CHAN_W + FINE_W;
   localparam int unsigned Y_W  = P2_W - 2;

   logic [P1_W-1:0] p1_in;
   logic [P2_W-1:0] p2_in;
   logic [P2_W-1:0] p3_in;

   logic              s3_valid_ff;
   sextant_type       s3_sext_ff;
   logic [CHAN_W-1:0] s3_val_ff;
   logic              s3_err_ff;
   logic [P1_W-1:0]   s3_p1_ff;
   logic [Y_W-1:0]    s3_y2_ff;
   logic [Y_W-1:0]    s3_y3_ff;

   always_comb begin
      p1_in = s2_val_ff * s2_t1_ff;
      p2_in = s2_val_ff * s2_t2_ff;
      p3_in = s2_val_ff * s2_t3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // The low two bits drop out: floor(p / 15300) = floor(floor(p / 4) / 3825).
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_sext_ff <= s2_sext_ff;
         s3_val_ff  <= s2_val_ff;
         s3_err_ff  <= s2_err_ff;
         s3_p1_ff   <= p1_in;
         s3_y2_ff   <= p2_in[P2_W-1:2];
         s3_y3_ff   <= p3_in[P2_W-1:2];
      end
   end

   // ---------------- Stage 4: divide by the constants ----------------
   localparam int unsigned QP_W = Y_W + RECIP_W;

   logic [P1_W:0]     c1_sum;
   logic [QP_W-1:0]   q2_prod;
   logic [QP_W-1:0]   q3_prod;
   logic [CHAN_W-1:0] c1_in;
   logic [CHAN_W-1:0] c2_in;
   logic [CHAN_W-1:0] c3_in;

   logic              s4_valid_ff;
   sextant_type       s4_sext_ff;
   logic [CHAN_W-1:0] s4_val_ff;
   logic              s4_err_ff;
   logic [CHAN_W-1:0] s4_c1_ff;
   logic [CHAN_W-1:0] s4_c2_ff;
   logic [CHAN_W-1:0] s4_c3_ff;

   // Division by 255 as (x + (x >> 8) + 1) >> 8, exact for x up to 255 * 255.
   // Division by 3825 as a multiply by the rounded-up reciprocal and a shift.
   always_comb begin
      c1_sum  = (P1_W + 1)'(s3_p1_ff) + (P1_W + 1)'(s3_p1_ff >> CHAN_W) + (P1_W + 1)'(1);
      c1_in   = c1_sum[CHAN_W +: CHAN_W];
      q2_prod = QP_W'(s3_y2_ff) * QP_W'(RECIP_3825);
      q3_prod = QP_W'(s3_y3_ff) * QP_W'(RECIP_3825);
      c2_in   = q2_prod[RECIP_SHIFT +: CHAN_W];
      c3_in   = q3_prod[RECIP_SHIFT +: CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_sext_ff <= s3_sext_ff;
         s4_val_ff  <= s3_val_ff;
         s4_err_ff  <= s3_err_ff;
         s4_c1_ff   <= c1_in;
         s4_c2_ff   <= c2_in;
         s4_c3_ff   <= c3_in;
      end
   end

   // ---------------- Stage 5: route levels to channels ----------------
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   logic [CHAN_W-1:0] red_ff;
   logic [CHAN_W-1:0] green_ff;
   logic [CHAN_W-1:0] blue_ff;
   logic              hue_error_ff;

   // Each sextant places brightness, the flat level and one ramp on the three channels.
   always_comb begin
      unique case (s4_sext_ff)
         SEXT_RED_YELLOW: begin
            red_in = s4_val_ff; green_in = s4_c3_ff;  blue_in = s4_c1_ff;
         end
         SEXT_YELLOW_GREEN: begin
            red_in = s4_c2_ff;  green_in = s4_val_ff; blue_in = s4_c1_ff;
         end
         SEXT_GREEN_CYAN: begin
            red_in = s4_c1_ff;  green_in = s4_val_ff; blue_in = s4_c3_ff;
         end
         SEXT_CYAN_BLUE: begin
            red_in = s4_c1_ff;  green_in = s4_c2_ff;  blue_in = s4_val_ff;
         end
         SEXT_BLUE_MAGENTA: begin
            red_in = s4_c3_ff;  green_in = s4_c1_ff;  blue_in = s4_val_ff;
         end
         default: begin
            red_in = s4_val_ff; green_in = s4_c1_ff;  blue_in = s4_c2_ff;
         end
      endcase
      // An out-of-range hue gives black.
      if (s4_err_ff) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         hue_error_ff <= s4_err_ff;
      end
   end

   // Response channel.
   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.red       = red_ff;
   assign rsp_bus.green     = green_ff;
   assign rsp_bus.blue      = blue_ff;
   assign rsp_bus.hue_error = hue_error_ff;

endmodule
